// ----- hdl/kmp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmp_pkg: shared types and constants of the streaming pattern matcher
// Opcodes, payload widths, parameter defaults and the per-beat command that
// is broadcast to every cell of the matcher row.
// ----------------------------------------------------------------------------
package kmp_pkg;

  localparam int OPCODE_W          = 2;
  localparam int BYTE_W            = 8;
  localparam int MATCH_W           = 32;
  localparam int MAX_PATTERN_DEF   = 32;
  localparam int POSITION_BITS_DEF = 32;

  typedef logic [OPCODE_W-1:0] opcode_t;
  typedef logic [BYTE_W-1:0]   byte_t;
  typedef logic [MATCH_W-1:0]  match_t;

  localparam opcode_t OP_CLEAR   = 2'd0;
  localparam opcode_t OP_APPEND  = 2'd1;
  localparam opcode_t OP_TEXT    = 2'd2;
  localparam opcode_t OP_RESTART = 2'd3;

  typedef struct packed {
    logic    en;
    opcode_t op;
    byte_t   data;
  } cell_cmd_t;

endpackage
`default_nettype wire

// ----- hdl/kmp_stream_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmp_stream_if: valid/ready channels of the pattern matcher
// The command channel carries an opcode and a byte per beat; the result
// channel carries the start position of one match per beat.
// ----------------------------------------------------------------------------
interface kmp_in_if;
  logic             valid;
  logic             ready;
  kmp_pkg::opcode_t opcode;
  kmp_pkg::byte_t   data_byte;

  modport source (output valid, output opcode, output data_byte, input ready);
  modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

interface kmp_out_if;
  logic            valid;
  logic            ready;
  kmp_pkg::match_t match_start;

  modport source (output valid, output match_start, input ready);
  modport sink   (input valid, input match_start, output ready);
endinterface
`default_nettype wire

// ----- hdl/kmp_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmp_cell: one pattern position of the matcher row
// Holds one pattern byte and one bit telling whether the text so far ends in
// the pattern prefix through this position; the bit moves to the next cell.
// ----------------------------------------------------------------------------
module kmp_cell #(
  parameter int IDX   = 0,
  parameter int LEN_W = 6
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  kmp_pkg::cell_cmd_t    cmd,
  input  wire  [LEN_W-1:0]      pat_len,
  input  wire                   prev_act,
  output logic                  act,
  output logic                  hit
);
  import kmp_pkg::*;

  byte_t byte_r;
  logic  act_r;
  logic  act_nxt;
  logic  in_use;
  logic  is_last;
  logic  step_act;

  assign in_use   = LEN_W'(IDX) < pat_len;
  assign is_last  = LEN_W'(IDX + 1) == pat_len;
  assign step_act = prev_act && in_use && (byte_r == cmd.data);
  assign hit      = cmd.en && (cmd.op == OP_TEXT) && step_act && is_last;
  assign act      = act_r;

  always_comb begin
    act_nxt = act_r;
    if (cmd.en) begin
      unique case (cmd.op)
        OP_CLEAR:   act_nxt = 1'b0;
        OP_RESTART: act_nxt = 1'b0;
        OP_TEXT:    act_nxt = step_act && !is_last;
        default:    act_nxt = act_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
    end else begin
      act_r <= act_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.en && (cmd.op == OP_APPEND) && (pat_len == LEN_W'(IDX))) begin
      byte_r <= cmd.data;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/kmp_stream_matcher.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmp_stream_matcher: streaming pattern matcher with overlapping matches
// A match result is valid in the cycle after the text beat that ends it.
// Throughput: one command beat per cycle, set by the cell row update; a
// result not yet taken holds the input until the output frees.
// Reset clears the pattern length, the match state and the text position.
// ----------------------------------------------------------------------------
module kmp_stream_matcher #(
  parameter int MAX_PATTERN   = kmp_pkg::MAX_PATTERN_DEF,
  parameter int POSITION_BITS = kmp_pkg::POSITION_BITS_DEF
) (
  input  wire       clk,
  input  wire       rst_n,
  kmp_in_if.sink    in_ch,
  kmp_out_if.source out_ch
);
  import kmp_pkg::*;

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);

  logic [LEN_W-1:0]         pat_len_r;
  logic [LEN_W-1:0]         pat_len_nxt;
  logic [POSITION_BITS-1:0] pos_r;
  logic [POSITION_BITS-1:0] pos_nxt;
  logic                     out_valid_r;
  logic                     out_valid_nxt;
  match_t                   out_start_r;
  logic [POSITION_BITS-1:0] start_pos;
  logic                     in_fire;
  logic                     any_hit;
  cell_cmd_t                cmd;
  logic [MAX_PATTERN:0]     chain;
  logic [MAX_PATTERN-1:0]   hits;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign cmd.en   = in_fire;
  assign cmd.op   = in_ch.opcode;
  assign cmd.data = in_ch.data_byte;

  assign chain[0] = 1'b1;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    kmp_cell #(
      .IDX   (k),
      .LEN_W (LEN_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .pat_len  (pat_len_r),
      .prev_act (chain[k]),
      .act      (chain[k+1]),
      .hit      (hits[k])
    );
  end

  assign any_hit   = |hits;
  assign start_pos = pos_r + POSITION_BITS'(1) - POSITION_BITS'(pat_len_r);

  always_comb begin
    pat_len_nxt = pat_len_r;
    pos_nxt     = pos_r;
    if (in_fire) begin
      unique case (in_ch.opcode)
        OP_CLEAR: begin
          pat_len_nxt = '0;
        end
        OP_APPEND: begin
          if (pat_len_r < LEN_W'(MAX_PATTERN)) begin
            pat_len_nxt = pat_len_r + LEN_W'(1);
          end
        end
        OP_TEXT: begin
          if (pat_len_r != '0) begin
            pos_nxt = pos_r + POSITION_BITS'(1);
          end
        end
        OP_RESTART: begin
          pos_nxt = '0;
        end
        default: begin
          pat_len_nxt = pat_len_r;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (in_fire && any_hit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_len_r   <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pat_len_r   <= pat_len_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && any_hit) begin
      out_start_r <= MATCH_W'(start_pos);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.match_start = out_start_r;

endmodule
`default_nettype wire
